// ===== design/teq_pkg.sv =====
package teq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_SERVICE  = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  localparam logic [2:0] KIND_FIRED     = 3'd0;
  localparam logic [2:0] KIND_SCHEDULED = 3'd1;
  localparam logic [2:0] KIND_FULL      = 3'd2;
  localparam logic [2:0] KIND_CANCELLED = 3'd3;
  localparam logic [2:0] KIND_CLEARED   = 3'd4;
  localparam logic [2:0] KIND_DONE      = 3'd5;
  localparam logic [2:0] KIND_IGNORED   = 3'd6;

  localparam logic [2:0] MODE_HOLD   = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_SHIFT  = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [31:0] due;
    logic [15:0] obj;
    logic [7:0]  evt;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    logic [2:0]  mode;
    entry_t      ins;
    logic [15:0] obj;
    logic [7:0]  evt;
    logic        any;
  } cell_ctl_t;

endpackage

// ===== design/timed_event_queue_unit.sv =====
// Schedule, clear and ignored commands: one result in the cycle after acceptance, busy stays low.
// Service: one fired result per cycle for each due entry as the cell row shifts toward
// the head, then the done marker. Cancel: one removal per cycle through the cell row.
// The receiver cannot stall results.
// Reset empties the queue and disables scheduling and cancel.
module timed_event_queue_unit
  import teq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_op,
  input  logic [15:0]      in_object_id,
  input  logic [7:0]       in_event_id,
  input  logic             in_cancel_any_event,
  input  logic [31:0]      in_payload_handle,
  input  logic [31:0]      in_delay,
  input  logic [31:0]      in_now,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  output logic             out_valid,
  output logic [2:0]       out_kind,
  output logic [15:0]      out_object,
  output logic [7:0]       out_event,
  output logic [31:0]      out_payload,
  output logic [31:0]      out_due_time,
  output logic [CNT_W-1:0] out_count,
  output logic             out_last
);

  cell_ctl_t ctl;
  entry_t    entries [QUEUE_DEPTH];
  logic      g       [QUEUE_DEPTH];
  logic      kill    [QUEUE_DEPTH];

  teq_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_object_id        (in_object_id),
    .in_event_id         (in_event_id),
    .in_cancel_any_event (in_cancel_any_event),
    .in_payload_handle   (in_payload_handle),
    .in_delay            (in_delay),
    .in_now              (in_now),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .head                (entries[0]),
    .full                (entries[QUEUE_DEPTH-1].valid),
    .any_kill            (kill[QUEUE_DEPTH-1]),
    .ctl                 (ctl),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_object          (out_object),
    .out_event           (out_event),
    .out_payload         (out_payload),
    .out_due_time        (out_due_time),
    .out_count           (out_count),
    .out_last            (out_last)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   g_prev;
    logic   kill_prev;

    if (i == 0) begin : g_first
      assign left_e    = '0;
      assign g_prev    = 1'b0;
      assign kill_prev = 1'b0;
    end else begin : g_mid
      assign left_e    = entries[i-1];
      assign g_prev    = g[i-1];
      assign kill_prev = kill[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = entries[i+1];
    end

    teq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_i      (left_e),
      .right_i     (right_e),
      .g_prev_i    (g_prev),
      .kill_prev_i (kill_prev),
      .entry_o     (entries[i]),
      .g_o         (g[i]),
      .kill_o      (kill[i])
    );
  end

endmodule

// ===== design/teq_cell.sv =====
module teq_cell
  import teq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    left_i,
  input  entry_t    right_i,
  input  logic      g_prev_i,
  input  logic      kill_prev_i,
  output entry_t    entry_o,
  output logic      g_o,
  output logic      kill_o
);

  entry_t entry_r;
  entry_t entry_nxt;

  assign g_o    = !entry_r.valid || ($signed(entry_r.due) > $signed(ctl.ins.due));
  assign kill_o = kill_prev_i || (entry_r.valid && (entry_r.obj == ctl.obj) &&
                                  (ctl.any || (entry_r.evt == ctl.evt)));
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.mode)
      MODE_INSERT: begin
        if (g_o && !g_prev_i) begin
          entry_nxt = ctl.ins;
        end else if (g_o && g_prev_i) begin
          entry_nxt = left_i;
        end
      end
      MODE_REMOVE: begin
        if (kill_o) begin
          entry_nxt = right_i;
        end
      end
      MODE_SHIFT: entry_nxt = right_i;
      MODE_CLEAR: entry_nxt.valid = 1'b0;
      default:    entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.due     <= entry_nxt.due;
    entry_r.obj     <= entry_nxt.obj;
    entry_r.evt     <= entry_nxt.evt;
    entry_r.payload <= entry_nxt.payload;
  end

endmodule

// ===== design/teq_ctrl.sv =====
module teq_ctrl
  import teq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_op,
  input  logic [15:0]      in_object_id,
  input  logic [7:0]       in_event_id,
  input  logic             in_cancel_any_event,
  input  logic [31:0]      in_payload_handle,
  input  logic [31:0]      in_delay,
  input  logic [31:0]      in_now,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  input  entry_t           head,
  input  logic             full,
  input  logic             any_kill,
  output cell_ctl_t        ctl,
  output logic             out_valid,
  output logic [2:0]       out_kind,
  output logic [15:0]      out_object,
  output logic [7:0]       out_event,
  output logic [31:0]      out_payload,
  output logic [31:0]      out_due_time,
  output logic [CNT_W-1:0] out_count,
  output logic             out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SVC  = 2'd1;
  localparam logic [1:0] ST_CAN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             enabled_r;
  logic [15:0]      obj_r, obj_nxt;
  logic [7:0]       evt_r, evt_nxt;
  logic             any_r, any_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             ov_r, ov_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [15:0]      oobj_r, oobj_nxt;
  logic [7:0]       oevt_r, oevt_nxt;
  logic [31:0]      opay_r, opay_nxt;
  logic [31:0]      odue_r, odue_nxt;
  logic [CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic             olast_r, olast_nxt;

  logic             accept;
  logic [31:0]      due_new;
  logic             fire;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign due_new   = in_now + in_delay;
  assign fire      = head.valid && !($signed(head.due) > $signed(now_r));

  always_comb begin
    state_nxt = state_r;
    obj_nxt   = obj_r;
    evt_nxt   = evt_r;
    any_nxt   = any_r;
    now_nxt   = now_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = 1'b0;
    kind_nxt  = KIND_IGNORED;
    oobj_nxt  = '0;
    oevt_nxt  = '0;
    opay_nxt  = '0;
    odue_nxt  = '0;
    ocnt_nxt  = '0;
    olast_nxt = 1'b0;

    ctl.mode        = MODE_HOLD;
    ctl.ins.valid   = 1'b1;
    ctl.ins.due     = due_new;
    ctl.ins.obj     = in_object_id;
    ctl.ins.evt     = in_event_id;
    ctl.ins.payload = in_payload_handle;
    ctl.obj         = obj_r;
    ctl.evt         = evt_r;
    ctl.any         = any_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          olast_nxt = 1'b1;
          priority if (in_op == OP_CLEAR) begin
            ctl.mode = MODE_CLEAR;
            ov_nxt   = 1'b1;
            kind_nxt = KIND_CLEARED;
          end else if (in_op == OP_SERVICE) begin
            now_nxt   = in_now;
            state_nxt = ST_SVC;
          end else if (!enabled_r) begin
            ov_nxt   = 1'b1;
            kind_nxt = KIND_IGNORED;
          end else if (in_op == OP_SCHEDULE) begin
            ov_nxt = 1'b1;
            if (full) begin
              kind_nxt = KIND_FULL;
            end else begin
              ctl.mode = MODE_INSERT;
              kind_nxt = KIND_SCHEDULED;
              odue_nxt = due_new;
            end
          end else begin
            obj_nxt   = in_object_id;
            evt_nxt   = in_event_id;
            any_nxt   = in_cancel_any_event;
            state_nxt = ST_CAN;
          end
        end
      end
      ST_SVC: begin
        ov_nxt = 1'b1;
        if (fire) begin
          ctl.mode = MODE_SHIFT;
          cnt_nxt  = cnt_r + 1'b1;
          kind_nxt = KIND_FIRED;
          oobj_nxt = head.obj;
          oevt_nxt = head.evt;
          opay_nxt = head.payload;
          odue_nxt = head.due;
        end else begin
          kind_nxt  = KIND_DONE;
          ocnt_nxt  = cnt_r;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CAN: begin
        if (any_kill) begin
          ctl.mode = MODE_REMOVE;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          ov_nxt    = 1'b1;
          kind_nxt  = KIND_CANCELLED;
          ocnt_nxt  = cnt_r;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      enabled_r <= 1'b0;
      ov_r      <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        enabled_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    obj_r   <= obj_nxt;
    evt_r   <= evt_nxt;
    any_r   <= any_nxt;
    now_r   <= now_nxt;
    kind_r  <= kind_nxt;
    oobj_r  <= oobj_nxt;
    oevt_r  <= oevt_nxt;
    opay_r  <= opay_nxt;
    odue_r  <= odue_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid    = ov_r;
  assign out_kind     = kind_r;
  assign out_object   = oobj_r;
  assign out_event    = oevt_r;
  assign out_payload  = opay_r;
  assign out_due_time = odue_r;
  assign out_count    = ocnt_r;
  assign out_last     = olast_r;

endmodule
